[hdl/asd_pkg.sv]
package asd_pkg;

  // Word capacity in symbols.
  localparam int MAX_LEN = 128;

  // Physical address into the word memory.
  localparam int ADDR_W = $clog2(MAX_LEN);
  // Stored length, 0..MAX_LEN.
  localparam int LEN_W = $clog2(MAX_LEN + 1);
  // Half length of a square, 0..MAX_LEN/2.
  localparam int K_W = $clog2(MAX_LEN / 2 + 1);
  // Signed letter-count difference between the two halves, -MAX_LEN/2..MAX_LEN/2.
  localparam int DIFF_W = K_W + 1;

  // Fixed field widths of the request and result.
  localparam int HALF_W = 7;
  localparam int WLEN_W = 8;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [K_W-1:0] k_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic [1:0] letter_t;

  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_APPEND  = 2'd1,
    KIND_PREPEND = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0] kind;
    letter_t    symbol;
    logic       commit;
  } req_t;

  typedef struct packed {
    logic [HALF_W-1:0] square_half_length;
    logic [WLEN_W-1:0] word_length;
    logic              refused;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DRAIN,
    S_FINISH
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic start;   // capture the request and clear the search state
    logic issue;   // read the three letters for the next half length
    logic finish;  // update the word and load the result register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_search;    // the incoming request needs a scan
    logic last_issue;   // the half length about to be issued is the largest one
    logic hit;          // a square has been found
    logic search_done;  // a square was found or every step has been checked
  } status_t;

endpackage

[hdl/asd_ram.sv]
module asd_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[hdl/asd_datapath.sv]
module asd_datapath (
  input  logic             clk,
  input  logic             rst,
  input  asd_pkg::cmd_t    cmd,
  input  asd_pkg::req_t    req,
  output asd_pkg::status_t status,
  output asd_pkg::res_t    res
);

  localparam int POS_W = asd_pkg::LEN_W + 1;
  localparam int SUM_W = asd_pkg::ADDR_W + 1;

  typedef logic [POS_W-1:0] pos_t;

  // The word sits in a circular buffer: logical position i lives at base + i.
  function automatic asd_pkg::addr_t phys_addr(input asd_pkg::addr_t b,
                                               input asd_pkg::len_t idx);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, b} + {1'b0, idx[asd_pkg::ADDR_W-1:0]};
    if (sum >= SUM_W'(asd_pkg::MAX_LEN)) begin
      sum = sum - SUM_W'(asd_pkg::MAX_LEN);
    end
    return sum[asd_pkg::ADDR_W-1:0];
  endfunction

  asd_pkg::addr_t   base;
  asd_pkg::len_t    len;
  asd_pkg::len_t    len_next;
  logic [1:0]       kind;
  asd_pkg::letter_t sym;
  logic             commit;

  asd_pkg::len_t    n;
  asd_pkg::k_t      maxk;
  asd_pkg::k_t      k;
  logic             right;
  logic             room;
  logic             ext_ok;

  pos_t             kk;
  pos_t             k2x;
  pos_t             pos [3];
  logic             is_new [3];
  asd_pkg::addr_t   raddr [3];

  logic             v1;
  asd_pkg::k_t      k1;
  logic             new1 [3];
  logic             v2;
  asd_pkg::k_t      k2;
  asd_pkg::diff_t   diffs [4];
  asd_pkg::diff_t   delta [4];
  logic             zero;
  logic             hit;
  asd_pkg::k_t      half;

  asd_pkg::letter_t a_o1, a_mid, b_o2, b_mid;
  asd_pkg::letter_t lm, lo1, lo2;

  logic             wr_en;
  asd_pkg::addr_t   waddr;
  asd_pkg::addr_t   base_dec;
  asd_pkg::addr_t   base_next;

  assign n     = len + asd_pkg::LEN_W'(1);
  assign maxk  = asd_pkg::K_W'(n >> 1);
  assign right = (kind == asd_pkg::KIND_APPEND);
  assign room  = (len < asd_pkg::LEN_W'(asd_pkg::MAX_LEN));

  // Entry 0 is the letter that moves from one half to the other; entries 1 and 2
  // are the two letters that join the far end of the square.
  always_comb begin
    kk  = POS_W'(k);
    k2x = kk << 1;
    if (right) begin
      pos[0] = POS_W'(n) - kk;
      pos[1] = POS_W'(n) - k2x + POS_W'(1);
      pos[2] = POS_W'(n) - k2x;
    end else begin
      pos[0] = kk - POS_W'(1);
      pos[1] = k2x - POS_W'(2);
      pos[2] = k2x - POS_W'(1);
    end
    for (int j = 0; j < 3; j++) begin
      if (right) begin
        is_new[j] = (pos[j] == POS_W'(len));
        raddr[j]  = phys_addr(base, asd_pkg::LEN_W'(pos[j]));
      end else begin
        is_new[j] = (pos[j] == '0);
        raddr[j]  = phys_addr(base, asd_pkg::LEN_W'(pos[j] - POS_W'(1)));
      end
    end
  end

  // Two copies of the word give three letter reads per cycle.
  asd_ram #(.WIDTH(2), .DEPTH(asd_pkg::MAX_LEN)) u_ram_a (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (waddr),
    .wdata   (sym),
    .raddr_a (raddr[1]),
    .raddr_b (raddr[0]),
    .rdata_a (a_o1),
    .rdata_b (a_mid)
  );

  asd_ram #(.WIDTH(2), .DEPTH(asd_pkg::MAX_LEN)) u_ram_b (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (waddr),
    .wdata   (sym),
    .raddr_a (raddr[2]),
    .raddr_b (raddr[0]),
    .rdata_a (b_o2),
    .rdata_b (b_mid)
  );

  assign lm  = new1[0] ? sym : a_mid;
  assign lo1 = new1[1] ? sym : a_o1;
  assign lo2 = new1[2] ? sym : b_o2;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      delta[c] = ((lm == 2'(c)) ? asd_pkg::diff_t'(2) : asd_pkg::diff_t'(0))
               - ((lo1 == 2'(c)) ? asd_pkg::diff_t'(1) : asd_pkg::diff_t'(0))
               - ((lo2 == 2'(c)) ? asd_pkg::diff_t'(1) : asd_pkg::diff_t'(0));
    end
  end

  assign zero = (diffs[0] == '0) && (diffs[1] == '0) && (diffs[2] == '0) && (diffs[3] == '0);

  // Word update at the end of an item.
  always_comb begin
    ext_ok   = ((kind == asd_pkg::KIND_APPEND) || (kind == asd_pkg::KIND_PREPEND)) && room;
    wr_en    = cmd.finish && ext_ok && commit;
    base_dec = (base == '0) ? asd_pkg::ADDR_W'(asd_pkg::MAX_LEN - 1)
                            : base - asd_pkg::ADDR_W'(1);
    waddr    = right ? phys_addr(base, len) : base_dec;
    base_next = (wr_en && !right) ? base_dec : base;
    if (kind == asd_pkg::KIND_CLEAR) begin
      len_next = '0;
    end else if (ext_ok && commit) begin
      len_next = len + asd_pkg::LEN_W'(1);
    end else begin
      len_next = len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
      len  <= '0;
      k    <= '0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      hit  <= 1'b0;
    end else begin
      if (cmd.start) begin
        k   <= asd_pkg::K_W'(1);
        v1  <= 1'b0;
        v2  <= 1'b0;
        hit <= 1'b0;
      end else begin
        v1 <= cmd.issue;
        v2 <= v1;
        if (cmd.issue) begin
          k <= k + asd_pkg::K_W'(1);
        end
        if (v2 && zero && !hit) begin
          hit <= 1'b1;
        end
      end
      if (cmd.finish) begin
        len  <= len_next;
        base <= base_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    k1 <= k;
    k2 <= k1;
    for (int j = 0; j < 3; j++) begin
      new1[j] <= is_new[j];
    end
    if (cmd.start) begin
      kind   <= req.kind;
      sym    <= req.symbol;
      commit <= req.commit;
      half   <= '0;
      for (int c = 0; c < 4; c++) begin
        diffs[c] <= '0;
      end
    end else begin
      if (v1) begin
        for (int c = 0; c < 4; c++) begin
          diffs[c] <= diffs[c] + delta[c];
        end
      end
      if (v2 && zero && !hit) begin
        half <= k2;
      end
    end
    if (cmd.finish) begin
      res.square_half_length <= asd_pkg::HALF_W'(half);
      res.word_length        <= asd_pkg::WLEN_W'(len_next);
      res.refused            <= ((kind == asd_pkg::KIND_APPEND) ||
                                 (kind == asd_pkg::KIND_PREPEND)) && !room;
    end
  end

  always_comb begin
    status.is_search   = ((req.kind == asd_pkg::KIND_APPEND) ||
                          (req.kind == asd_pkg::KIND_PREPEND)) && room && (maxk != '0);
    status.last_issue  = (k == maxk);
    status.hit         = hit;
    status.search_done = hit || (!v1 && !v2);
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= asd_pkg::LEN_W'(asd_pkg::MAX_LEN))
    else $error("stored length exceeds the word capacity");

  a_base_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, base} < SUM_W'(asd_pkg::MAX_LEN))
    else $error("circular buffer base out of range");

  a_copies_agree: assert property (@(posedge clk) disable iff (rst)
    (v1 && !new1[0]) |-> (a_mid == b_mid))
    else $error("the two word copies disagree");

  a_first_hit: assert property (@(posedge clk) disable iff (rst)
    (v2 && zero && !hit && !cmd.start) |=> (hit && (half == $past(k2))))
    else $error("smallest square half length not captured");
`endif

endmodule

[hdl/asd_controller.sv]
module asd_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             res_ready,
  input  asd_pkg::status_t status,
  output logic             req_ready,
  output logic             res_valid,
  output asd_pkg::cmd_t    cmd
);

  asd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= asd_pkg::S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      asd_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.start  = 1'b1;
          state_next = status.is_search ? asd_pkg::S_SEARCH : asd_pkg::S_FINISH;
        end
      end
      asd_pkg::S_SEARCH: begin
        if (status.hit) begin
          state_next = asd_pkg::S_FINISH;
        end else begin
          cmd.issue = 1'b1;
          if (status.last_issue) begin
            state_next = asd_pkg::S_DRAIN;
          end
        end
      end
      asd_pkg::S_DRAIN: begin
        if (status.search_done) begin
          state_next = asd_pkg::S_FINISH;
        end
      end
      asd_pkg::S_FINISH: begin
        if (!res_valid || res_ready) begin
          cmd.finish = 1'b1;
          state_next = asd_pkg::S_IDLE;
        end
      end
      default: state_next = asd_pkg::S_IDLE;
    endcase
  end

endmodule

[hdl/abelian_square_end_detector_top.sv]
// Abelian square end detector.
// A request on the req channel (req_valid/req_ready, payload req) clears the
// stored word, appends a letter at its right end or prepends one at its left end.
// For every request exactly one result leaves on the res channel
// (res_valid/res_ready, payload res): the smallest half length of an abelian
// square at the extended end, the stored length afterwards and a refused flag.
// A clear, an unused kind, a refused extension or an extension of an empty
// word skips the scan and goes from acceptance straight to the finish step,
// which loads the result register; the controller then returns to idle.
// An extension scans half lengths 1 up to (length+1)/2, one half length per
// cycle, and stops at the first square. The scan rate is set by the three
// letter reads each step needs, served by two copies of the word memory with
// two read ports each. One request is worked on at a time.
// Reset empties the word; the memory itself is not cleared and needs no pass.
// When the receiver stalls, the finished result waits in the output register,
// and the block still accepts and processes the next request, holding its
// result back until the previous one has been taken.
module abelian_square_end_detector_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  asd_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output asd_pkg::res_t res
);

  // Command and status between the sequencer and the datapath.
  asd_pkg::cmd_t    cmd;
  asd_pkg::status_t status;

  // The controller owns the handshakes and the scan sequencing.
  asd_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .res_ready (res_ready),
    .status    (status),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .cmd       (cmd)
  );

  // The datapath holds the word in a circular buffer so that a prepend only
  // moves the base pointer, and keeps four running letter-count differences
  // that are updated incrementally as the half length grows.
  asd_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .req    (req),
    .status (status),
    .res    (res)
  );

endmodule
